>>> sv/clr_pkg.sv
package clr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_W          = 12;
    localparam int REG_IDX_W      = 3;

    localparam logic [REG_IDX_W-1:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_ENABLE    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_LEFT      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_RIGHT     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_TOP       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_BOTTOM    = 3'd6;

    localparam logic [CFG_W-1:0] SURFACE_RESET = 12'd2048;

    // step direction codes, two's complement -1 / 0 / +1
    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_PIXEL = 2'd1,
        ACT_VRUN  = 2'd2,
        ACT_HRUN  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        OUT_STEP,
        OUT_SETUP,
        OUT_RUN
    } out_kind_t;

    typedef struct packed {
        logic      load_start;
        logic      setup;
        logic      pixel;
        logic      run_start;
        logic      run_step;
        logic      out_load;
        out_kind_t out_kind;
    } clr_cmd_t;

    typedef struct packed {
        logic done_now;
        logic x_major;
        logic run_go;
    } clr_status_t;

endpackage

>>> sv/clr_datapath.sv
module clr_datapath
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [REG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_wdata,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  clr_cmd_t                     cmd,
    output clr_status_t                  status,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         visible,
    output logic                         done_res
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int EW = C + 3;
    localparam int CW = ((C > 13) ? C : 13) + 1;

    // configuration
    logic [CFG_W-1:0] surface_width_reg;
    logic [CFG_W-1:0] surface_height_reg;
    logic             clip_enable_reg;
    logic [CFG_W-1:0] clip_left_reg;
    logic [CFG_W-1:0] clip_right_reg;
    logic [CFG_W-1:0] clip_top_reg;
    logic [CFG_W-1:0] clip_bottom_reg;

    // line state
    logic signed [C-1:0]  cur_x_reg;
    logic signed [C-1:0]  cur_y_reg;
    logic signed [C-1:0]  stop_x_reg;
    logic signed [C-1:0]  stop_y_reg;
    logic [DW-1:0]        tdx_reg;
    logic [DW-1:0]        tdy_reg;
    logic [1:0]           dir_x_reg;
    logic [1:0]           dir_y_reg;
    logic signed [EW-1:0] err_reg;
    logic signed [EW-1:0] diag_reg;
    logic [DW-1:0]        inc_reg;
    logic                 x_major_reg;
    logic                 moved_reg;

    // output register
    logic signed [C-1:0] point_x_reg;
    logic signed [C-1:0] point_y_reg;
    logic                visible_reg;
    logic                done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg  <= SURFACE_RESET;
            surface_height_reg <= SURFACE_RESET;
            clip_enable_reg    <= 1'b0;
            clip_left_reg      <= '0;
            clip_right_reg     <= '0;
            clip_top_reg       <= '0;
            clip_bottom_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SURFACE_WIDTH:  surface_width_reg  <= cfg_wdata;
                REG_SURFACE_HEIGHT: surface_height_reg <= cfg_wdata;
                REG_CLIP_ENABLE:    clip_enable_reg    <= cfg_wdata[0];
                REG_CLIP_LEFT:      clip_left_reg      <= cfg_wdata;
                REG_CLIP_RIGHT:     clip_right_reg     <= cfg_wdata;
                REG_CLIP_TOP:       clip_top_reg       <= cfg_wdata;
                REG_CLIP_BOTTOM:    clip_bottom_reg    <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // start setup: order endpoints by y, deltas from both subtraction orders
    logic                swap;
    logic signed [C-1:0] x0, y0, x1, y1;
    logic signed [DW-1:0] dx, ndx, dy, ndy;
    logic [DW-1:0]       abs_dx, abs_dy;
    logic [1:0]          dir_x_calc, dir_y_calc;

    always_comb
    begin
        swap   = start_y > end_y;
        x0     = swap ? end_x : start_x;
        y0     = swap ? end_y : start_y;
        x1     = swap ? start_x : end_x;
        y1     = swap ? start_y : end_y;
        dx     = {x1[C-1], x1} - {x0[C-1], x0};
        ndx    = {x0[C-1], x0} - {x1[C-1], x1};
        dy     = {y1[C-1], y1} - {y0[C-1], y0};
        ndy    = {y0[C-1], y0} - {y1[C-1], y1};
        abs_dx = dx[DW-1] ? ndx : dx;
        abs_dy = dy[DW-1] ? ndy : dy;
        dir_x_calc = dx[DW-1] ? DIR_NEG : ((dx != '0) ? DIR_POS : DIR_ZERO);
        dir_y_calc = dy[DW-1] ? DIR_NEG : ((dy != '0) ? DIR_POS : DIR_ZERO);
    end

    // error setup of start, after the endpoint load: error and increments
    logic                 x_major_calc;
    logic signed [EW-1:0] err_calc;
    logic signed [EW-1:0] diag_calc;

    always_comb
    begin
        x_major_calc = tdx_reg > tdy_reg;
        if (x_major_calc)
        begin
            err_calc  = $signed({2'b00, tdy_reg}) - $signed({3'b000, tdx_reg[DW-1:1]});
            diag_calc = $signed({2'b00, tdy_reg}) - $signed({2'b00, tdx_reg});
        end
        else
        begin
            err_calc  = $signed({2'b00, tdx_reg}) - $signed({3'b000, tdy_reg[DW-1:1]});
            diag_calc = $signed({2'b00, tdx_reg}) - $signed({2'b00, tdy_reg});
        end
    end

    // stepping
    logic                 err_neg;
    logic                 at_stop;
    logic signed [C-1:0]  dir_x_ext, dir_y_ext;
    logic signed [C-1:0]  adv_x, adv_y;
    logic signed [C-1:0]  nx, ny;
    logic signed [EW-1:0] err_inc;
    logic signed [EW-1:0] err_diag;
    logic                 do_pixel;

    always_comb
    begin
        err_neg   = err_reg[EW-1];
        at_stop   = x_major_reg ? (cur_x_reg == stop_x_reg) : (cur_y_reg == stop_y_reg);
        dir_x_ext = {{(C-2){dir_x_reg[1]}}, dir_x_reg};
        dir_y_ext = {{(C-2){dir_y_reg[1]}}, dir_y_reg};
        adv_x     = cur_x_reg + dir_x_ext;
        adv_y     = cur_y_reg + dir_y_ext;
        nx        = (x_major_reg || !err_neg) ? adv_x : cur_x_reg;
        ny        = (!x_major_reg || !err_neg) ? adv_y : cur_y_reg;
        err_inc   = err_reg + $signed({2'b00, inc_reg});
        err_diag  = err_reg + diag_reg;
        do_pixel  = cmd.pixel && !at_stop;
    end

    assign status.done_now = at_stop;
    assign status.x_major  = x_major_reg;
    assign status.run_go   = err_neg && !at_stop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            stop_x_reg  <= '0;
            stop_y_reg  <= '0;
            tdx_reg     <= '0;
            tdy_reg     <= '0;
            dir_x_reg   <= DIR_ZERO;
            dir_y_reg   <= DIR_ZERO;
            err_reg     <= '0;
            diag_reg    <= '0;
            inc_reg     <= '0;
            x_major_reg <= 1'b0;
            moved_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                cur_x_reg  <= x0;
                cur_y_reg  <= y0;
                stop_x_reg <= x1;
                stop_y_reg <= y1;
                tdx_reg    <= {abs_dx[C-1:0], 1'b0};
                tdy_reg    <= {abs_dy[C-1:0], 1'b0};
                dir_x_reg  <= dir_x_calc;
                dir_y_reg  <= dir_y_calc;
            end
            if (cmd.setup)
            begin
                x_major_reg <= x_major_calc;
                err_reg     <= err_calc;
                diag_reg    <= diag_calc;
                inc_reg     <= x_major_calc ? tdy_reg : tdx_reg;
            end
            if (do_pixel)
            begin
                cur_x_reg <= nx;
                cur_y_reg <= ny;
                err_reg   <= err_neg ? err_inc : err_diag;
            end
            if (cmd.run_start)
            begin
                moved_reg <= 1'b0;
            end
            if (cmd.run_step)
            begin
                if (x_major_reg)
                begin
                    cur_x_reg <= adv_x;
                end
                else
                begin
                    cur_y_reg <= adv_y;
                end
                err_reg   <= err_inc;
                moved_reg <= 1'b1;
            end
        end
    end

    // visibility window
    logic signed [CW-1:0] xmin, xmax, ymin, ymax;
    logic signed [CW-1:0] cl, cr, ct, cb, sw, sh;
    logic signed [C-1:0]  pt_x, pt_y;
    logic signed [CW-1:0] px, py;
    logic                 in_window;
    logic                 moved;
    logic                 vis_qual;

    always_comb
    begin
        cl = {{(CW-CFG_W){clip_left_reg[CFG_W-1]}}, clip_left_reg};
        cr = {{(CW-CFG_W){clip_right_reg[CFG_W-1]}}, clip_right_reg};
        ct = {{(CW-CFG_W){clip_top_reg[CFG_W-1]}}, clip_top_reg};
        cb = {{(CW-CFG_W){clip_bottom_reg[CFG_W-1]}}, clip_bottom_reg};
        sw = {{(CW-CFG_W){1'b0}}, surface_width_reg};
        sh = {{(CW-CFG_W){1'b0}}, surface_height_reg};
        xmin = (clip_enable_reg && cl > 0) ? cl : '0;
        ymin = (clip_enable_reg && ct > 0) ? ct : '0;
        xmax = (clip_enable_reg && cr < sw) ? cr : sw;
        ymax = (clip_enable_reg && cb < sh) ? cb : sh;

        pt_x = do_pixel ? nx : cur_x_reg;
        pt_y = do_pixel ? ny : cur_y_reg;
        px   = {{(CW-C){pt_x[C-1]}}, pt_x};
        py   = {{(CW-C){pt_y[C-1]}}, pt_y};
        in_window = (px >= xmin) && (px < xmax) && (py >= ymin) && (py < ymax);
        moved     = (pt_x != cur_x_reg) || (pt_y != cur_y_reg);

        case (cmd.out_kind)
            OUT_STEP:  vis_qual = !at_stop && moved;
            OUT_SETUP: vis_qual = 1'b1;
            OUT_RUN:   vis_qual = moved_reg;
            default:   vis_qual = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            point_x_reg <= pt_x;
            point_y_reg <= pt_y;
            visible_reg <= vis_qual && in_window;
            done_reg    <= (cmd.out_kind == OUT_STEP) && at_stop;
        end
    end

    assign point_x  = point_x_reg;
    assign point_y  = point_y_reg;
    assign visible  = visible_reg;
    assign done_res = done_reg;

endmodule

>>> sv/clr_controller.sv
module clr_controller
    import clr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    output logic        out_valid,
    input  logic        out_stall,
    input  clr_status_t status,
    output clr_cmd_t    cmd
);

    state_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;
    logic    accept;
    action_t act;
    logic    run_matches;

    assign act         = action_t'(action);
    assign out_free    = !out_valid_reg || !out_stall;
    assign in_stall    = !((state_reg == ST_IDLE) && out_free);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    // run only along the major axis, and only while the error is negative
    assign run_matches = !status.done_now && status.run_go &&
                         (((act == ACT_VRUN) && !status.x_major) ||
                          ((act == ACT_HRUN) && status.x_major));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (act == ACT_START)
                    begin
                        state_next = ST_SETUP;
                    end
                    else if (act != ACT_PIXEL && run_matches)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_SETUP:
            begin
                state_next = ST_IDLE;
            end
            ST_RUN:
            begin
                if (!status.run_go && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.out_kind = OUT_STEP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (act)
                        ACT_START:
                        begin
                            cmd.load_start = 1'b1;
                        end
                        ACT_PIXEL:
                        begin
                            cmd.pixel    = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        default:
                        begin
                            if (run_matches)
                            begin
                                cmd.run_start = 1'b1;
                            end
                            else
                            begin
                                cmd.out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                cmd.setup    = 1'b1;
                cmd.out_load = 1'b1;
                cmd.out_kind = OUT_SETUP;
            end
            ST_RUN:
            begin
                if (status.run_go)
                begin
                    cmd.run_step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_RUN;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = cmd.out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_needs_free_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending transaction");

    a_start_goes_to_setup: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && act == ACT_START) |=> (state_reg == ST_SETUP))
        else $error("start transaction did not enter setup");

    a_setup_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP) |=> out_valid_reg)
        else $error("setup finished without a result");

    a_run_step_not_at_stop: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.run_step |-> !status.done_now)
        else $error("run stepped past the endpoint");
`endif

endmodule

>>> sv/clipped_line_rasterizer.sv
// Pixel steps and non-moving steps load their result in the cycle after acceptance;
//   start loads the endpoints, then sets up the error and gives its result with it.
// Pixel steps are taken one per cycle while the output is not stalled; a run steps
//   one pixel per cycle through the major-axis adder, taking no input until it ends.
// Reset (rst_n, asynchronous, active low): clears the controller, the line state and
//   the output valid, and returns the configuration registers to their reset values.
module clipped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [REG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         visible,
    output logic                         done_res
);

    clr_cmd_t    cmd;
    clr_status_t status;

    clr_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    clr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .cmd       (cmd),
        .status    (status),
        .point_x   (point_x),
        .point_y   (point_y),
        .visible   (visible),
        .done_res  (done_res)
    );

endmodule
